@@ rtl/core/lprfd_pkg.sv @@
// lprfd_pkg: shared types, widths, register indexes and reset values
// for the leg-pair row frame detector; no dependencies
`default_nettype none

package lprfd_pkg;

    localparam int PIXEL_W = 8;
    localparam int WIDTH_W = 7;
    localparam int RUNS_W  = 3;
    localparam int LEGS_W  = 2;
    localparam int ROWS_W  = 10;
    localparam int RATIO_W = 17;
    localparam int FRAC_W  = 16;
    localparam int INDEX_W = 3;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [WIDTH_W-1:0] width_t;
    typedef logic [RUNS_W-1:0]  runs_t;
    typedef logic [LEGS_W-1:0]  legs_t;
    typedef logic [ROWS_W-1:0]  rows_t;
    typedef logic [RATIO_W-1:0] ratio_t;
    typedef logic [INDEX_W-1:0] cfg_index_t;

    // saturation points
    localparam width_t WIDTH_SAT = 7'd127;
    localparam runs_t  RUNS_SAT  = 3'd7;
    localparam legs_t  LEGS_SAT  = 2'd3;
    localparam rows_t  MAX_ROWS  = 10'd1023;
    localparam legs_t  LEGS_PAIR = 2'd2;

    typedef enum logic [INDEX_W-1:0] {
        REG_PIXEL_LEVEL   = 3'd0,
        REG_MIN_LEG_WIDTH = 3'd1,
        REG_MAX_LEG_WIDTH = 3'd2,
        REG_RUN_LIMIT     = 3'd3,
        REG_COUNT_RATIO   = 3'd4,
        REG_STREAK_RATIO  = 3'd5
    } cfg_reg_e;

    localparam pixel_t RST_PIXEL_LEVEL   = 8'd128;
    localparam width_t RST_MIN_LEG_WIDTH = 7'd6;
    localparam width_t RST_MAX_LEG_WIDTH = 7'd66;
    localparam runs_t  RST_RUN_LIMIT     = 3'd4;
    localparam ratio_t RST_COUNT_RATIO   = 17'd0;
    // 0.13 in Q1.16, rounded to nearest
    localparam ratio_t RST_STREAK_RATIO  = 17'd8520;

    typedef struct packed {
        pixel_t pixel_level;
        width_t min_leg_width;
        width_t max_leg_width;
        runs_t  run_limit;
        ratio_t count_ratio;
        ratio_t streak_ratio;
    } cfg_t;

    typedef struct packed {
        logic match;
    } row_stat_t;

    typedef struct packed {
        rows_t matched_rows;
        rows_t longest_streak;
        rows_t row_total;
    } frame_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/lprfd_pix_if.sv @@
// lprfd_pix_if: pixel stream channel, one pixel per beat
// depends on lprfd_pkg
`default_nettype none

interface lprfd_pix_if;
    logic              valid;
    logic              ready;
    lprfd_pkg::pixel_t pixel;
    logic              row_end;
    logic              frame_end;

    modport source (output valid, output pixel, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel, input row_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/lprfd_res_if.sv @@
// lprfd_res_if: frame result channel, one result per beat
// depends on lprfd_pkg
`default_nettype none

interface lprfd_res_if;
    logic             valid;
    logic             ready;
    logic             found;
    lprfd_pkg::rows_t matched_rows;
    lprfd_pkg::rows_t longest_streak;
    lprfd_pkg::rows_t row_total;

    modport source (output valid, output found, output matched_rows,
                    output longest_streak, output row_total, input ready);
    modport sink   (input valid, input found, input matched_rows,
                    input longest_streak, input row_total, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lprfd_cfg_if.sv @@
// lprfd_cfg_if: configuration write channel, register index plus data
// depends on lprfd_pkg
`default_nettype none

interface lprfd_cfg_if;
    logic                  valid;
    logic                  ready;
    lprfd_pkg::cfg_index_t index;
    lprfd_pkg::ratio_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/leg_pair_row_frame_detector_core.sv @@
// leg pair row frame detector: top level, pixel pipeline, frame counters
// and result register; depends on lprfd_pkg, the three channel interfaces,
// lprfd_row_scan and lprfd_ratio_check
// path: a frame_end pixel beat passes the input, frame count and result registers
// throughput: one pixel beat per cycle unless a frame_end beat waits on the result
//   side; row scan and frame counters close their loops on the input register
// reset: configuration returns to its defaults, row and frame state clear,
//   pipeline and result register empty
`default_nettype none

module leg_pair_row_frame_detector_core (
    input  wire logic clk,
    input  wire logic rst_n,
    lprfd_pix_if.sink   pix,
    lprfd_cfg_if.sink   cfg,
    lprfd_res_if.source res
);
    import lprfd_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // input register: one pixel beat
    logic   in_valid_reg;
    pixel_t in_pixel_reg;
    logic   in_row_end_reg;
    logic   in_frame_end_reg;

    // frame counters
    rows_t rows_seen_reg, rows_seen_next;
    rows_t match_count_reg, match_count_next;
    rows_t streak_now_reg, streak_now_next;
    rows_t streak_best_reg, streak_best_next;

    // frame count register, waiting for the ratio test
    logic        stat_valid_reg;
    frame_stat_t stat_reg;
    frame_stat_t stat_next;

    // result register
    logic        res_valid_reg;
    logic        res_found_reg;
    frame_stat_t res_stat_reg;

    row_stat_t row_stat;
    logic      row_done;
    logic      found;

    // handshake chain
    logic res_free;
    logic stat_go;
    logic stat_free;
    logic in_go;

    // result register empties or is being taken
    assign res_free  = !res_valid_reg || res.ready;
    assign stat_go   = stat_valid_reg && res_free;
    assign stat_free = !stat_valid_reg || stat_go;
    // a pixel that closes no frame never waits on the result side
    assign in_go     = in_valid_reg && (!in_frame_end_reg || stat_free);
    assign pix.ready = !in_valid_reg || in_go;

    // configuration is taken at any time
    assign cfg.ready = 1'b1;

    // a frame end always closes the row too
    assign row_done = in_row_end_reg || in_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_level   <= RST_PIXEL_LEVEL;
            cfg_reg.min_leg_width <= RST_MIN_LEG_WIDTH;
            cfg_reg.max_leg_width <= RST_MAX_LEG_WIDTH;
            cfg_reg.run_limit     <= RST_RUN_LIMIT;
            cfg_reg.count_ratio   <= RST_COUNT_RATIO;
            cfg_reg.streak_ratio  <= RST_STREAK_RATIO;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PIXEL_LEVEL:   cfg_reg.pixel_level   <= cfg.data[PIXEL_W-1:0];
                REG_MIN_LEG_WIDTH: cfg_reg.min_leg_width <= cfg.data[WIDTH_W-1:0];
                REG_MAX_LEG_WIDTH: cfg_reg.max_leg_width <= cfg.data[WIDTH_W-1:0];
                REG_RUN_LIMIT:     cfg_reg.run_limit     <= cfg.data[RUNS_W-1:0];
                REG_COUNT_RATIO:   cfg_reg.count_ratio   <= cfg.data;
                REG_STREAK_RATIO:  cfg_reg.streak_ratio  <= cfg.data;
                default:           ; // unused indexes are dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pix.ready)
        begin
            in_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            in_pixel_reg     <= pix.pixel;
            in_row_end_reg   <= pix.row_end;
            in_frame_end_reg <= pix.frame_end;
        end
    end

    lprfd_row_scan u_row_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_go),
        .pixel   (in_pixel_reg),
        .row_end (row_done),
        .cfg     (cfg_reg),
        .stat    (row_stat)
    );

    // frame counters, updated on each row close
    always_comb
    begin
        rows_seen_next   = rows_seen_reg;
        match_count_next = match_count_reg;
        streak_now_next  = streak_now_reg;
        streak_best_next = streak_best_reg;

        if (row_done)
        begin
            rows_seen_next = (rows_seen_reg < MAX_ROWS) ? rows_seen_reg + 1'b1 : MAX_ROWS;
            if (row_stat.match)
            begin
                match_count_next = (match_count_reg < MAX_ROWS) ?
                                   match_count_reg + 1'b1 : MAX_ROWS;
                streak_now_next  = (streak_now_reg < MAX_ROWS) ?
                                   streak_now_reg + 1'b1 : MAX_ROWS;
                if (streak_now_next > streak_best_reg)
                begin
                    streak_best_next = streak_now_next;
                end
            end
            else
            begin
                streak_now_next = '0;
            end
        end

        // counts that go out with this frame
        stat_next.matched_rows   = match_count_next;
        stat_next.longest_streak = streak_best_next;
        stat_next.row_total      = rows_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_seen_reg   <= '0;
            match_count_reg <= '0;
            streak_now_reg  <= '0;
            streak_best_reg <= '0;
        end
        else if (in_go)
        begin
            if (in_frame_end_reg)
            begin
                // next frame starts from zero
                rows_seen_reg   <= '0;
                match_count_reg <= '0;
                streak_now_reg  <= '0;
                streak_best_reg <= '0;
            end
            else
            begin
                rows_seen_reg   <= rows_seen_next;
                match_count_reg <= match_count_next;
                streak_now_reg  <= streak_now_next;
                streak_best_reg <= streak_best_next;
            end
        end
    end

    // frame count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_valid_reg <= 1'b0;
        end
        else if (stat_free)
        begin
            stat_valid_reg <= in_go && in_frame_end_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat_free && in_go && in_frame_end_reg)
        begin
            stat_reg <= stat_next;
        end
    end

    lprfd_ratio_check u_ratio_check (
        .stat         (stat_reg),
        .count_ratio  (cfg_reg.count_ratio),
        .streak_ratio (cfg_reg.streak_ratio),
        .found        (found)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= stat_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat_go)
        begin
            res_found_reg <= found;
            res_stat_reg  <= stat_reg;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.found          = res_found_reg;
    assign res.matched_rows   = res_stat_reg.matched_rows;
    assign res.longest_streak = res_stat_reg.longest_streak;
    assign res.row_total      = res_stat_reg.row_total;

endmodule

`default_nettype wire

@@ rtl/core/lprfd_row_scan.sv @@
// lprfd_row_scan: per-row bright run tracking and row match decision
// depends on lprfd_pkg
`default_nettype none

module lprfd_row_scan (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire lprfd_pkg::pixel_t    pixel,
    input  wire logic                 row_end,
    input  wire lprfd_pkg::cfg_t      cfg,
    output lprfd_pkg::row_stat_t      stat
);
    import lprfd_pkg::*;

    logic   prev_bright_reg, prev_bright_next;
    width_t run_width_reg, run_width_next;
    runs_t  ended_runs_reg, ended_runs_next;
    legs_t  leg_runs_reg, leg_runs_next;

    logic   bright;
    logic   run_ends;
    logic   in_band;
    width_t width_upd;
    runs_t  ended_upd;
    legs_t  legs_upd;

    always_comb
    begin
        bright   = pixel > cfg.pixel_level;
        run_ends = !bright && prev_bright_reg;
        in_band  = (run_width_reg >= cfg.min_leg_width) &&
                   (run_width_reg < cfg.max_leg_width);

        if (bright)
        begin
            width_upd = (run_width_reg < WIDTH_SAT) ? run_width_reg + 1'b1 : WIDTH_SAT;
        end
        else
        begin
            width_upd = '0;
        end

        ended_upd = ended_runs_reg;
        legs_upd  = leg_runs_reg;
        if (run_ends)
        begin
            ended_upd = (ended_runs_reg < RUNS_SAT) ? ended_runs_reg + 1'b1 : RUNS_SAT;
            if (in_band)
            begin
                legs_upd = (leg_runs_reg < LEGS_SAT) ? leg_runs_reg + 1'b1 : LEGS_SAT;
            end
        end

        // decision uses the counts after this pixel
        stat.match = (ended_upd < cfg.run_limit) && (legs_upd == LEGS_PAIR);

        if (row_end)
        begin
            prev_bright_next = 1'b0;
            run_width_next   = '0;
            ended_runs_next  = '0;
            leg_runs_next    = '0;
        end
        else
        begin
            prev_bright_next = bright;
            run_width_next   = width_upd;
            ended_runs_next  = ended_upd;
            leg_runs_next    = legs_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bright_reg <= 1'b0;
            run_width_reg   <= '0;
            ended_runs_reg  <= '0;
            leg_runs_reg    <= '0;
        end
        else if (advance)
        begin
            prev_bright_reg <= prev_bright_next;
            run_width_reg   <= run_width_next;
            ended_runs_reg  <= ended_runs_next;
            leg_runs_reg    <= leg_runs_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lprfd_ratio_check.sv @@
// lprfd_ratio_check: division-free Q1.16 ratio tests on frame counts
// depends on lprfd_pkg
`default_nettype none

module lprfd_ratio_check (
    input  wire lprfd_pkg::frame_stat_t stat,
    input  wire lprfd_pkg::ratio_t      count_ratio,
    input  wire lprfd_pkg::ratio_t      streak_ratio,
    output logic                        found
);
    import lprfd_pkg::*;

    localparam int PROD_W = RATIO_W + ROWS_W;

    logic [PROD_W-1:0] count_lhs, count_rhs;
    logic [PROD_W-1:0] streak_lhs, streak_rhs;

    always_comb
    begin
        // count * 2^16 against ratio * rows
        count_lhs  = PROD_W'({stat.matched_rows, FRAC_W'(0)});
        streak_lhs = PROD_W'({stat.longest_streak, FRAC_W'(0)});
        count_rhs  = PROD_W'(count_ratio) * PROD_W'(stat.row_total);
        streak_rhs = PROD_W'(streak_ratio) * PROD_W'(stat.row_total);
        found      = (count_lhs > count_rhs) && (streak_lhs > streak_rhs);
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_leg_pair_row_frame_detector_core.sv @@
// testbench for leg_pair_row_frame_detector_core: streams pixel rows and
// frames, predicts each frame result in a scoreboard class and checks it
// depends on lprfd_pkg, lprfd_pix_if, lprfd_cfg_if, lprfd_res_if and the core
`timescale 1ns / 1ps

module tb_leg_pair_row_frame_detector_core;
    import lprfd_pkg::*;

    // register indexes that map to no register, written once as noise
    localparam cfg_index_t SPARE_INDEX_LO = 3'd6;
    localparam cfg_index_t SPARE_INDEX_HI = 3'd7;

    localparam int HOLD_CYCLES    = 300;   // long result back-pressure stretch
    localparam int HOLD_FRAMES    = 40;    // tiny frames pushed during the hold
    localparam int SETTLE_CYCLES  = 8;     // lets the pipeline empty after the last result
    localparam int RANDOM_PIXELS  = 1400;
    localparam int RANDOM_RESULTS = 40;
    localparam int SAT_ROWS       = 1030;  // enough rows to saturate the row counters

    typedef struct packed {
        logic  found;
        rows_t matched_rows;
        rows_t longest_streak;
        rows_t row_total;
    } frame_result_t;

    // frame result predictor with its own copy of registers and row/frame state
    class frame_scoreboard;
        cfg_t          regs;
        logic          prev_bright;
        width_t        run_width;
        runs_t         ended_runs;
        legs_t         leg_runs;
        rows_t         rows_seen;
        rows_t         match_count;
        rows_t         streak_now;
        rows_t         streak_best;
        frame_result_t frame_q[$];
        int            errors;

        function new();
            regs.pixel_level   = RST_PIXEL_LEVEL;
            regs.min_leg_width = RST_MIN_LEG_WIDTH;
            regs.max_leg_width = RST_MAX_LEG_WIDTH;
            regs.run_limit     = RST_RUN_LIMIT;
            regs.count_ratio   = RST_COUNT_RATIO;
            regs.streak_ratio  = RST_STREAK_RATIO;
            clear_row();
            clear_frame();
            errors = 0;
        endfunction

        function void clear_row();
            prev_bright = 1'b0;
            run_width   = '0;
            ended_runs  = '0;
            leg_runs    = '0;
        endfunction

        function void clear_frame();
            rows_seen   = '0;
            match_count = '0;
            streak_now  = '0;
            streak_best = '0;
        endfunction

        function rows_t bump_rows(rows_t v);
            return (v == MAX_ROWS) ? v : v + 1'b1;
        endfunction

        function void write_reg(cfg_index_t idx, ratio_t data);
            case (idx)
                REG_PIXEL_LEVEL:   regs.pixel_level   = data[PIXEL_W-1:0];
                REG_MIN_LEG_WIDTH: regs.min_leg_width = data[WIDTH_W-1:0];
                REG_MAX_LEG_WIDTH: regs.max_leg_width = data[WIDTH_W-1:0];
                REG_RUN_LIMIT:     regs.run_limit     = data[RUNS_W-1:0];
                REG_COUNT_RATIO:   regs.count_ratio   = data;
                REG_STREAK_RATIO:  regs.streak_ratio  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return frame_q.size();
        endfunction

        // one accepted pixel beat
        function void note_pixel(pixel_t p, logic row_end, logic frame_end);
            logic          bright;
            logic          row_hit;
            logic          count_ok;
            logic          streak_ok;
            frame_result_t r;
            bright = p > regs.pixel_level;
            if (bright) begin
                if (run_width != WIDTH_SAT)
                    run_width = run_width + 1'b1;
            end else begin
                if (prev_bright) begin
                    if (run_width >= regs.min_leg_width && run_width < regs.max_leg_width &&
                        leg_runs != LEGS_SAT)
                        leg_runs = leg_runs + 1'b1;
                    if (ended_runs != RUNS_SAT)
                        ended_runs = ended_runs + 1'b1;
                end
                run_width = '0;
            end
            prev_bright = bright;

            // frame end closes the row as well
            if (row_end || frame_end) begin
                row_hit   = (ended_runs < regs.run_limit) && (leg_runs == LEGS_PAIR);
                rows_seen = bump_rows(rows_seen);
                if (row_hit) begin
                    match_count = bump_rows(match_count);
                    streak_now  = bump_rows(streak_now);
                    if (streak_now > streak_best)
                        streak_best = streak_now;
                end else begin
                    streak_now = '0;
                end
                clear_row();
            end

            if (frame_end) begin
                count_ok  = (64'(match_count) << FRAC_W) > 64'(regs.count_ratio) * 64'(rows_seen);
                streak_ok = (64'(streak_best) << FRAC_W) > 64'(regs.streak_ratio) * 64'(rows_seen);
                r.found          = count_ok && streak_ok;
                r.matched_rows   = match_count;
                r.longest_streak = streak_best;
                r.row_total      = rows_seen;
                frame_q.push_back(r);
                clear_frame();
            end
        endfunction

        function void compare_field(string field, rows_t want, rows_t got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // one accepted result beat
        function void check_result(logic found, rows_t matched, rows_t streak, rows_t total);
            frame_result_t want;
            if (frame_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual found=%0b matched=%0d streak=%0d rows=%0d",
                         $time, found, matched, streak, total);
                errors++;
                return;
            end
            want = frame_q.pop_front();
            compare_field("found", rows_t'(want.found), rows_t'(found));
            compare_field("matched_rows", want.matched_rows, matched);
            compare_field("longest_streak", want.longest_streak, streak);
            compare_field("row_total", want.row_total, total);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lprfd_pix_if pix();
    lprfd_cfg_if cfg();
    lprfd_res_if res();

    leg_pair_row_frame_detector_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .res   (res)
    );

    frame_scoreboard sb;
    pixel_t          row_q[$];      // pixels of the row being built
    int              pixels_sent;   // accepted pixel beats
    int              results_done;  // accepted result beats
    bit              source_idle;   // random gaps on the pixel side
    bit              sink_idle;     // random stalls on the result side
    int              source_odds;
    int              sink_odds;
    int              hold_id;       // bumped to request one long result hold

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // gap / stall burst frequency: often, now and then, almost never
    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 2;
            1:       return 8;
            default: return 100000;
        endcase
    endfunction

    function automatic ratio_t pick_ratio();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 17'd65536;
            2:       return ratio_t'($urandom);
            default: return ratio_t'($urandom_range(0, 52000));
        endcase
    endfunction

    // brightness relative to the current level; at level 255 nothing is bright
    function automatic pixel_t bright_value();
        if (sb.regs.pixel_level == 8'd255)
            return 8'd255;
        return pixel_t'($urandom_range(sb.regs.pixel_level + 1, 255));
    endfunction

    function automatic pixel_t dark_value();
        return pixel_t'($urandom_range(0, sb.regs.pixel_level));
    endfunction

    function automatic void add_pixels(pixel_t v, int n);
        repeat (n) row_q.push_back(v);
    endfunction

    function automatic void add_bright(int n);
        repeat (n) row_q.push_back(bright_value());
    endfunction

    function automatic void add_dark(int n);
        repeat (n) row_q.push_back(dark_value());
    endfunction

    // mostly a width inside the leg band, kept short; otherwise just outside it or a short random width
    function automatic int leg_width();
        int lo;
        int hi;
        lo = sb.regs.min_leg_width;
        hi = sb.regs.max_leg_width;
        if (lo < hi && $urandom_range(0, 4) != 0) begin
            hi = (hi - 1 < lo + 8) ? hi - 1 : lo + 8;
            return $urandom_range(lo, hi);
        end
        case ($urandom_range(0, 2))
            0:       return (lo > 0) ? lo - 1 : 0;
            1:       return hi;
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    // one row into row_q: mostly two-leg rows, then one leg, three legs,
    // too many short runs, and plain noise
    function automatic void build_row();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                add_dark($urandom_range(0, 2));
                add_bright(leg_width());
                add_dark($urandom_range(1, 3));
                add_bright(leg_width());
                add_dark($urandom_range(1, 2));
                // run left open at the row end, never counted
                if ($urandom_range(0, 4) == 0)
                    add_bright($urandom_range(1, 3));
            end
            6:
            begin
                add_dark($urandom_range(0, 1));
                add_bright(leg_width());
                add_dark(1);
            end
            7:
            begin
                repeat (3)
                begin
                    add_bright(leg_width());
                    add_dark($urandom_range(1, 2));
                end
            end
            8:
            begin
                repeat ($urandom_range(3, 8))
                begin
                    add_bright($urandom_range(1, 3));
                    add_dark($urandom_range(1, 2));
                end
            end
            default:
            begin
                repeat ($urandom_range(1, 16)) row_q.push_back(pixel_t'($urandom));
            end
        endcase
        if (row_q.size() == 0)
            add_dark(1);
    endfunction

    // one pixel beat, with an optional gap in front of it
    task automatic send_pixel(pixel_t p, logic re, logic fe);
        if (source_idle && $urandom_range(0, source_odds) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pix.valid     <= 1'b1;
        pix.pixel     <= p;
        pix.row_end   <= re;
        pix.frame_end <= fe;
        do @(posedge clk); while (!pix.ready);
        sb.note_pixel(p, re, fe);
        pixels_sent++;
    endtask

    // drains row_q; a frame end may come with or without row_end
    task automatic send_row(bit close_frame, bit mark_row);
        bit last;
        for (int i = 0; i < row_q.size(); i++) begin
            last = (i == row_q.size() - 1);
            send_pixel(row_q[i], last && (mark_row || !close_frame), last && close_frame);
        end
        row_q.delete();
    endtask

    task automatic send_frame(int rows);
        for (int r = 0; r < rows; r++) begin
            build_row();
            send_row(r == rows - 1, $urandom_range(0, 1));
        end
    endtask

    task automatic random_frames(int n);
        repeat (n)
        begin
            source_odds = pick_odds();
            send_frame(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 7));
        end
    endtask

    // wait until every frame result is back, then let the pipeline empty
    task automatic settle();
        pix.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg.valid stays high between beats; the caller lowers it
    task automatic write_reg(cfg_index_t idx, ratio_t data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        sb.write_reg(idx, data);
    endtask

    // writes all six registers, junk in the unused upper data bits
    task automatic apply_config(pixel_t level, width_t lo, width_t hi, runs_t limit,
                                ratio_t cr, ratio_t sr, bit spare);
        write_reg(REG_PIXEL_LEVEL,   {9'($urandom), level});
        write_reg(REG_MIN_LEG_WIDTH, {10'($urandom), lo});
        write_reg(REG_MAX_LEG_WIDTH, {10'($urandom), hi});
        write_reg(REG_RUN_LIMIT,     {14'($urandom), limit});
        write_reg(REG_COUNT_RATIO,   cr);
        write_reg(REG_STREAK_RATIO,  sr);
        if (spare) begin
            write_reg(SPARE_INDEX_LO, ratio_t'($urandom));
            write_reg(SPARE_INDEX_HI, ratio_t'($urandom));
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic random_config();
        pixel_t level;
        width_t lo;
        width_t hi;
        level = ($urandom_range(0, 5) == 0) ? pixel_t'($urandom)
                                             : pixel_t'($urandom_range(60, 200));
        lo    = width_t'($urandom_range(0, 10));
        // an empty band now and then
        hi    = ($urandom_range(0, 7) == 0) ? width_t'($urandom_range(0, 127))
                                             : width_t'(lo + $urandom_range(1, 12));
        apply_config(level, lo, hi, runs_t'($urandom_range(0, 7)),
                     pick_ratio(), pick_ratio(), 1'b0);
    endtask

    // result side: checks every result beat, stalls in bursts, and holds off
    // for a long stretch once asked so that the core backs up into its input
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        sink_odds  = 8;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready) begin
                sb.check_result(res.found, res.matched_rows, res.longest_streak, res.row_total);
                results_done++;
            end
            if (hold_id != hold_seen) begin
                hold_seen  = hold_id;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && sink_idle && $urandom_range(0, sink_odds) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                res.ready <= 1'b0;
                stall_left--;
            end else begin
                res.ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                sink_odds = pick_odds();
        end
    end

    // stimulus
    initial
    begin
        int start_pixels;
        int phase;
        rst_n         <= 1'b0;
        pix.valid     <= 1'b0;
        pix.pixel     <= '0;
        pix.row_end   <= 1'b0;
        pix.frame_end <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.index     <= '0;
        cfg.data      <= '0;
        hold_id       <= 0;
        pixels_sent  = 0;
        results_done = 0;
        source_idle  = 1'b1;
        sink_idle    = 1'b1;
        source_odds  = 8;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset configuration
        // row with two legs, the second ended by a dark last pixel at the level
        add_pixels(8'd255, 6);
        add_pixels(8'd0, 1);
        add_pixels(8'd129, 6);
        add_pixels(8'd128, 1);
        send_row(1'b0, 1'b1);
        // short run, then a bright last pixel whose run stays uncounted
        add_pixels(8'd129, 3);
        add_pixels(8'd0, 1);
        add_pixels(8'd255, 1);
        send_row(1'b0, 1'b1);
        // frame end without row end still closes a row
        add_pixels(8'd0, 1);
        send_row(1'b1, 1'b0);
        // one-pixel frames, with and without row end
        add_pixels(8'd255, 1);
        send_row(1'b1, 1'b1);
        add_pixels(8'd0, 1);
        send_row(1'b1, 1'b0);
        settle();
        start_pixels = pixels_sent;

        // widest band, everything but zero bright, ratios at zero;
        // runs past the width saturation point must never look like legs
        apply_config(8'd0, 7'd0, 7'd127, 3'd7, 17'd0, 17'd0, 1'b0);
        add_bright(130);
        add_dark(1);
        add_bright(5);
        add_dark(1);
        send_row(1'b0, 1'b1);
        add_bright(127);
        add_dark(1);
        add_bright(126);
        add_dark(1);
        send_row(1'b1, 1'b1);
        random_frames(6);
        settle();

        // nothing bright, band empty at the top, run limit zero,
        // ratios at and above one; also writes to unused indexes
        apply_config(8'd255, 7'd127, 7'd127, 3'd0, 17'd65536, 17'h1FFFF, 1'b1);
        random_frames(4);
        settle();

        // inverted band, run limit one
        apply_config(8'd128, 7'd20, 7'd5, 3'd1, 17'd65535, 17'd65536, 1'b0);
        random_frames(4);
        settle();

        // random configurations; the third phase pushes tiny frames into a long hold
        phase = 0;
        while (pixels_sent - start_pixels < RANDOM_PIXELS || results_done < RANDOM_RESULTS) begin
            random_config();
            if (phase == 2) begin
                hold_id <= hold_id + 1;
                repeat (HOLD_FRAMES) send_frame(1);
            end else begin
                random_frames($urandom_range(5, 10));
            end
            settle();
            phase++;
        end

        // tall frame of matching rows: all row counters saturate, then a
        // small frame shows that they cleared
        apply_config(8'd128, 7'd1, 7'd127, 3'd7, 17'd60000, 17'd65000, 1'b0);
        for (int r = 0; r < SAT_ROWS; r++) begin
            add_bright(1);
            add_dark(1);
            add_bright(1);
            add_dark(1);
            send_row(r == SAT_ROWS - 1, 1'b1);
        end
        send_frame(3);
        settle();

        // last stretch at full rate on both sides
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        random_config();
        random_frames(4);
        settle();

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
